@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define SFK_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sfk assertion failed");

// clocked assertion that also holds through reset
`define SFK_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("sfk assertion failed");

`endif

@@ sv/sfk_pkg.sv @@
// types, constants and helper functions of the scara forward kinematics block
package sfk_pkg;

    // field widths
    localparam int AW  = 16;            // binary angle
    localparam int DW  = 16;            // slide extension and config data
    localparam int OW  = 18;            // output position
    localparam int XW  = 32;            // cordic x/y, Q26
    localparam int ZW  = 33;            // cordic angle, 2^32 per turn
    localparam int SW  = XW + 2;        // sum of two cordic terms
    localparam int X0W = 30;            // starting vector length

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 2'd1;

    localparam logic [DW-1:0] LINK_LENGTH_RESET = 16'd4096;
    localparam logic [DW-1:0] BASE_HEIGHT_RESET = 16'd4096;

    // cordic gain in Q30
    localparam logic [X0W-1:0] GAIN_Q30 = 30'd652032874;
    localparam logic [X0W-1:0] X0_RESET =
        X0W'((64'(LINK_LENGTH_RESET) * 64'(GAIN_Q30)) >> 16);

    localparam int ROUND_HALF = 8192;
    localparam int ROUND_SH   = 14;
    localparam int OUT_MAX    = 131071;
    localparam int OUT_MIN    = -131072;

    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;

    localparam int ATAN_LEN = 24;
    localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
        30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
        30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
        30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D,
        30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    typedef struct packed {
        rot_t                 r1;     // rotation by joint 1
        rot_t                 r12;    // rotation by joint 1 plus joint 2
        logic                 neg1;
        logic                 neg12;
        logic signed [OW-1:0] pz;
    } lane_t;

    typedef struct packed {
        logic                 neg;
        logic signed [ZW-1:0] z;
    } fold_t;

    // bring the angle into +-quarter turn, flag a half turn shift
    function automatic fold_t fold_angle(input logic signed [AW-1:0] a);
        fold_t                r;
        logic signed [AW:0]   ext;
        ext   = {a[AW-1], a};
        r.neg = 1'b0;
        if (ext > (AW+1)'(QUARTER_TURN)) begin
            ext   = ext - (AW+1)'(HALF_TURN);
            r.neg = 1'b1;
        end else if (ext < -(AW+1)'(QUARTER_TURN)) begin
            ext   = ext + (AW+1)'(HALF_TURN);
            r.neg = 1'b1;
        end
        r.z = {ext, 16'h0000};
        return r;
    endfunction

    // one cordic micro-rotation
    function automatic rot_t cordic_step(input rot_t r, input int unsigned sh,
                                         input logic signed [ZW-1:0] step);
        rot_t n;
        if (!r.z[ZW-1]) begin
            n.x = r.x - (r.y >>> sh);
            n.y = r.y + (r.x >>> sh);
            n.z = r.z - step;
        end else begin
            n.x = r.x + (r.y >>> sh);
            n.y = r.y - (r.x >>> sh);
            n.z = r.z + step;
        end
        return n;
    endfunction

    // round Q26 sum to Q12 and clamp to output range
    function automatic logic signed [OW-1:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] q;
        q = (s + SW'(ROUND_HALF)) >>> ROUND_SH;
        if (q > SW'(OUT_MAX)) begin
            q = SW'(OUT_MAX);
        end else if (q < SW'(OUT_MIN)) begin
            q = SW'(OUT_MIN);
        end
        return OW'(q);
    endfunction

endpackage

@@ sv/sfk_cordic_cell.sv @@
// one cordic cell: a micro-rotation of both angles with its own handshake stage
module sfk_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sfk_pkg::lane_t in_lane,
    output logic          out_valid,
    input  logic          out_ready,
    output sfk_pkg::lane_t out_lane
);
    import sfk_pkg::*;

    localparam logic signed [ZW-1:0] ATAN_STEP = $signed({{(ZW-30){1'b0}}, ATAN_TAB[STAGE]});

    logic  valid_reg;
    logic  valid_next;
    logic  load;
    lane_t lane_reg;
    lane_t lane_next;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        lane_next     = in_lane;
        lane_next.r1  = cordic_step(in_lane.r1, STAGE, ATAN_STEP);
        lane_next.r12 = cordic_step(in_lane.r12, STAGE, ATAN_STEP);
        valid_next    = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;

endmodule

@@ sv/sfk_combine.sv @@
// undo the half turn fold, add both links, round and clamp to the output
module sfk_combine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sfk_pkg::lane_t                in_lane,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [sfk_pkg::OW-1:0] out_x,
    output logic signed [sfk_pkg::OW-1:0] out_y,
    output logic signed [sfk_pkg::OW-1:0] out_z
);
    import sfk_pkg::*;

    // sign stage
    logic                 a_valid_reg;
    logic                 a_valid_next;
    logic                 a_ready;
    logic                 a_load;
    logic signed [XW-1:0] c1_reg, c12_reg, s1_reg, s12_reg;
    logic signed [XW-1:0] c1_next, c12_next, s1_next, s12_next;
    logic signed [OW-1:0] az_reg;

    // sum stage
    logic                 b_valid_reg;
    logic                 b_valid_next;
    logic                 b_ready;
    logic                 b_load;
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [OW-1:0] x_reg, y_reg, z_reg;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;
    assign a_load   = in_valid && a_ready;
    assign b_load   = a_valid_reg && b_ready;

    always_comb begin
        c1_next      = in_lane.neg1  ? -in_lane.r1.x  : in_lane.r1.x;
        s1_next      = in_lane.neg1  ? -in_lane.r1.y  : in_lane.r1.y;
        c12_next     = in_lane.neg12 ? -in_lane.r12.x : in_lane.r12.x;
        s12_next     = in_lane.neg12 ? -in_lane.r12.y : in_lane.r12.y;
        a_valid_next = a_ready ? in_valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        sum_x        = SW'(c1_reg) + SW'(c12_reg);
        sum_y        = SW'(s1_reg) + SW'(s12_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            c1_reg  <= c1_next;
            c12_reg <= c12_next;
            s1_reg  <= s1_next;
            s12_reg <= s12_next;
            az_reg  <= in_lane.pz;
        end
        if (b_load) begin
            x_reg <= round_sat(sum_x);
            y_reg <= round_sat(sum_y);
            z_reg <= az_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

@@ sv/scara_forward_kinematics.sv @@
// top level of the scara forward kinematics block: config, prep stage, cordic chain, back end
//
//  channel   dir  handshake          payload
//  s_        in   s_valid/s_ready    s_joint1_angle, s_joint2_angle, s_slide_extension
//  m_        out  m_valid/m_ready    m_pos_x, m_pos_y, m_pos_z
//  cfg_      in   cfg_wr_en          cfg_wr_index, cfg_wr_data (no wait, no read-back)
//
// one item per cycle sustained while m_ready stays high; the path is the prep stage,
// one cell per cordic stage (capped at 24 cells), the sign stage and the sum/round stage
// every stage has its own valid bit and ready, so bubbles close up under a stall
// and a new item is taken while a finished result waits in the output register
// reset (aresetn low, synchronous) empties all stages and reloads the config
// registers with link_length = 4096 and base_height = 4096
module scara_forward_kinematics #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sfk_pkg::AW-1:0]      s_joint1_angle,
    input  logic signed [sfk_pkg::AW-1:0]      s_joint2_angle,
    input  logic signed [sfk_pkg::DW-1:0]      s_slide_extension,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [sfk_pkg::OW-1:0]      m_pos_x,
    output logic signed [sfk_pkg::OW-1:0]      m_pos_y,
    output logic signed [sfk_pkg::OW-1:0]      m_pos_z,

    input  logic                               cfg_wr_en,
    input  logic [sfk_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  logic [sfk_pkg::DW-1:0]             cfg_wr_data
);
    import sfk_pkg::*;

    // the angle table only has 24 entries
    localparam int N = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;

    // ------------------------------------------------------------------
    // config registers
    // link length is kept already scaled by the cordic gain: x0 = L*K in Q26,
    // so the multiply sits on the config write path, not in the datapath
    // ------------------------------------------------------------------
    logic [X0W-1:0]     x0_reg;
    logic [DW-1:0]      base_height_reg;
    logic [DW+X0W-1:0]  x0_prod;

    assign x0_prod = (DW+X0W)'(cfg_wr_data) * (DW+X0W)'(GAIN_Q30);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg          <= X0_RESET;
            base_height_reg <= BASE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_LINK_LENGTH: x0_reg          <= x0_prod[DW+X0W-1:16];
                REG_BASE_HEIGHT: base_height_reg <= cfg_wr_data;
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // prep stage: angle sum, quarter turn fold, start vector, z position
    // ------------------------------------------------------------------
    logic                 p_valid_reg;
    logic                 p_valid_next;
    logic                 p_load;
    lane_t                p_lane_reg;
    lane_t                p_lane_next;
    logic signed [AW-1:0] a12;
    fold_t                f1;
    fold_t                f12;

    // chain wiring, index 0 is the prep stage output
    lane_t chain_lane  [N+1];
    logic  chain_valid [N+1];
    logic  chain_ready [N+1];

    assign s_ready = !p_valid_reg || chain_ready[0];
    assign p_load  = s_valid && s_ready;

    always_comb begin
        // angle sum wraps once around the full turn
        a12 = s_joint1_angle + s_joint2_angle;
        f1  = fold_angle(s_joint1_angle);
        f12 = fold_angle(a12);

        p_lane_next.r1.x  = $signed({{(XW-X0W){1'b0}}, x0_reg});
        p_lane_next.r1.y  = '0;
        p_lane_next.r1.z  = f1.z;
        p_lane_next.r12.x = $signed({{(XW-X0W){1'b0}}, x0_reg});
        p_lane_next.r12.y = '0;
        p_lane_next.r12.z = f12.z;
        p_lane_next.neg1  = f1.neg;
        p_lane_next.neg12 = f12.neg;
        // signed 16 plus unsigned 16 always fits the 18 bit output, no clamp
        p_lane_next.pz    = $signed({{(OW-DW){s_slide_extension[DW-1]}}, s_slide_extension})
                          + $signed({{(OW-DW){1'b0}}, base_height_reg});

        p_valid_next = s_ready ? s_valid : p_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_load) begin
            p_lane_reg <= p_lane_next;
        end
    end

    // ------------------------------------------------------------------
    // cordic chain: one cell per stage, each shifts by its own stage number
    // ------------------------------------------------------------------
    assign chain_valid[0] = p_valid_reg;
    assign chain_lane[0]  = p_lane_reg;

    for (genvar i = 0; i < N; i++) begin : g_cell
        sfk_cordic_cell #(
            .STAGE(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_lane   (chain_lane[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_lane  (chain_lane[i+1])
        );
    end

    // ------------------------------------------------------------------
    // back end: unfold sign, add the two links, round to Q12, clamp
    // ------------------------------------------------------------------
    sfk_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[N]),
        .in_ready  (chain_ready[N]),
        .in_lane   (chain_lane[N]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_pos_x),
        .out_y     (m_pos_y),
        .out_z     (m_pos_z)
    );

endmodule

@@ sv/sfk_checker.sv @@
// port level checks of the scara forward kinematics block and their bind
`include "assert_macros.svh"

module sfk_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [17:0] m_pos_x,
    input logic signed [17:0] m_pos_y,
    input logic signed [17:0] m_pos_z
);

    // reset empties the output register
    `SFK_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // with the output register empty every stage behind it can move
    `SFK_ASSERT(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready)

    // a held result keeps its value
    `SFK_ASSERT(a_hold_result, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y) && $stable(m_pos_z))

    // z is a signed 16 bit slide plus an unsigned 16 bit offset
    `SFK_ASSERT(a_z_range, aclk, aresetn, m_valid |-> m_pos_z >= -18'sd32768 && m_pos_z <= 18'sd98302)

endmodule

bind scara_forward_kinematics sfk_checker u_sfk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_pos_x (m_pos_x),
    .m_pos_y (m_pos_y),
    .m_pos_z (m_pos_z)
);
